>>> rtl/vca_pkg.sv
// Shared types and constants for the voice channel allocator.
`default_nettype none

package vca_pkg;

  typedef enum logic [2:0] {
    CMD_PLAY   = 3'd0,
    CMD_STOP   = 3'd1,
    CMD_PAUSE  = 3'd2,
    CMD_RESUME = 3'd3,
    CMD_QUERY  = 3'd4,
    CMD_STOPALL = 3'd5,
    CMD_ENDED  = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_HALT    = 3'd2,
    ACT_PAUSE   = 3'd3,
    ACT_RESUME  = 3'd4,
    ACT_HALTALL = 3'd5
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_e;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_UNKNOWN = 2'd1;

  localparam logic [1:0] REASON_FREE    = 2'd0;
  localparam logic [1:0] REASON_SAME    = 2'd1;
  localparam logic [1:0] REASON_LOOPING = 2'd2;
  localparam logic [1:0] REASON_OLDEST  = 2'd3;

  localparam logic [1:0] SSTATE_STOPPED = 2'd0;
  localparam logic [1:0] SSTATE_PLAYING = 2'd1;
  localparam logic [1:0] SSTATE_PAUSED  = 2'd2;

  // One stored channel entry.
  typedef struct packed {
    logic [31:0] handle;
    logic [7:0]  sound;
    logic        looping;
    logic        paused;
  } entry_t;

  // Running minimum handles of the three steal candidate sets.
  typedef struct packed {
    logic        same_vld;
    logic [31:0] same_h;
    logic        loop_vld;
    logic [31:0] loop_h;
    logic        any_vld;
    logic [31:0] any_h;
  } best_t;

  // Verdict of the compare unit for one entry.
  typedef struct packed {
    logic key_hit;
    logic same_better;
    logic loop_better;
    logic any_better;
  } cmp_res_t;

  typedef struct packed {
    logic [1:0]  status;
    act_e        action;
    logic [5:0]  channel;
    logic [31:0] new_handle;
    logic        start_looping;
    logic [7:0]  start_sound;
    logic [1:0]  steal_reason;
    logic [1:0]  sound_state;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/vca_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module vca_ram #(
  parameter int WIDTH = 42,
  parameter int DEPTH = 8
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/vca_cmp.sv
// Shared compare unit: judges one channel entry against the key and the running minimums.
`default_nettype none

module vca_cmp
  import vca_pkg::*;
(
  input  wire logic        busy_i,
  input  wire entry_t      ent_i,
  input  wire logic [31:0] key_i,
  input  wire logic [7:0]  sound_i,
  input  wire best_t       best_i,
  output cmp_res_t         res_o
);

  always_comb begin
    res_o.key_hit     = busy_i && (key_i != 32'd0) && (ent_i.handle == key_i);
    res_o.same_better = busy_i && (ent_i.sound == sound_i) &&
                        (!best_i.same_vld || (ent_i.handle < best_i.same_h));
    res_o.loop_better = busy_i && ent_i.looping &&
                        (!best_i.loop_vld || (ent_i.handle < best_i.loop_h));
    res_o.any_better  = busy_i && (!best_i.any_vld || (ent_i.handle < best_i.any_h));
  end

endmodule

`default_nettype wire

>>> rtl/voice_channel_allocator.sv
// Top level of the voice channel allocator: sequencer, channel state and output register.
`default_nettype none

// Flow: a play, stop, pause, resume or query word sweeps the table in ST_SCAN, then ST_WRITE
// forms the result and ST_DONE loads it into the output register; other words skip ST_SCAN.
// The table RAM is swept one entry per cycle, and each entry passes the one shared compare unit.
// One word is in work at a time, and the input is ready again once the sequencer is back in
// ST_IDLE after the result is registered.
// A held output stalls the sequencer in ST_DONE. Reset clears all busy flags and the handle counter at once.
module voice_channel_allocator
  import vca_pkg::*;
#(
  parameter int NUM_CHANNELS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata, from bit 0 up: sound_id[7:0], loop_request[8], handle[40:9],
  // ended_channel[46:41], zero fill [47].
  input  wire logic [47:0] s_axis_tdata,
  // tuser: command[2:0].
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata, from bit 0 up: status[1:0], channel[7:2], new_handle[39:8],
  // start_looping[40], start_sound[48:41], steal_reason[50:49],
  // sound_state[52:51], zero fill [55:53].
  output logic      [55:0] m_axis_tdata,
  // tuser: mixer_action[2:0].
  output logic      [2:0]  m_axis_tuser
);

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [CW:0] LAST_CNT = (CW + 1)'(NUM_CHANNELS);
  localparam logic [6:0]  NUM_CH7  = 7'(NUM_CHANNELS);

  state_e state_q, state_d;

  // Accepted word.
  cmd_e        cmd_q, cmd_d;
  logic [7:0]  snd_q, snd_d;
  logic        loop_q, loop_d;
  logic [31:0] hdl_q, hdl_d;
  logic [5:0]  end_q, end_d;
  logic [31:0] nh_q, nh_d;

  // Sweep control.
  logic [CW:0]   cnt_q, cnt_d;
  logic          pend_q, pend_d;
  logic [CW-1:0] pidx_q, pidx_d;

  // Sweep results.
  logic          find_vld_q, find_vld_d;
  logic [CW-1:0] fidx_q, fidx_d;
  entry_t        fent_q, fent_d;
  best_t         best_q, best_d;
  logic [CW-1:0] same_idx_q, same_idx_d;
  logic [CW-1:0] loop_idx_q, loop_idx_d;
  logic [CW-1:0] any_idx_q, any_idx_d;
  logic [NUM_CHANNELS-1:0] coll_q, coll_d;

  // Channel state kept in flip-flops.
  logic [NUM_CHANNELS-1:0] busy_q, busy_d;
  logic [31:0]             hcnt_q, hcnt_d;

  // Result path.
  res_t res_q, res_d;
  res_t out_q, out_d;
  logic out_vld_q, out_vld_d;

  // Table RAM ports.
  logic          ram_we;
  logic [CW-1:0] ram_waddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;

  cmp_res_t      cmp_res;
  logic [31:0]   cmp_key;

  logic          in_acc;
  logic          issuing;
  logic          free_vld;
  logic [CW-1:0] free_idx;
  logic          needs_scan;
  logic [31:0]   cnt_inc;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign issuing       = (state_q == ST_SCAN) && (cnt_q != LAST_CNT);
  assign cmp_key       = (cmd_q == CMD_PLAY) ? nh_q : hdl_q;
  assign cnt_inc       = hcnt_q + 32'd1;

  always_comb begin
    unique case (cmd_e'(s_axis_tuser))
      CMD_PLAY, CMD_STOP, CMD_PAUSE, CMD_RESUME, CMD_QUERY: needs_scan = 1'b1;
      default:                                              needs_scan = 1'b0;
    endcase
  end

  vca_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_CHANNELS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[CW-1:0]),
    .rdata_o (ram_rdata)
  );

  vca_cmp u_cmp (
    .busy_i  (busy_q[pidx_q]),
    .ent_i   (ram_rdata),
    .key_i   (cmp_key),
    .sound_i (snd_q),
    .best_i  (best_q),
    .res_o   (cmp_res)
  );

  // Lowest free channel.
  always_comb begin
    free_vld = 1'b0;
    free_idx = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_vld = 1'b1;
        free_idx = CW'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = needs_scan ? ST_SCAN : ST_WRITE;
        end
      end
      ST_SCAN: begin
        if (!issuing && pend_q) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    logic [CW-1:0] pick;
    logic [1:0]    reason;
    entry_t        upd;

    cmd_d      = cmd_q;
    snd_d      = snd_q;
    loop_d     = loop_q;
    hdl_d      = hdl_q;
    end_d      = end_q;
    nh_d       = nh_q;
    cnt_d      = cnt_q;
    pend_d     = 1'b0;
    pidx_d     = pidx_q;
    find_vld_d = find_vld_q;
    fidx_d     = fidx_q;
    fent_d     = fent_q;
    best_d     = best_q;
    same_idx_d = same_idx_q;
    loop_idx_d = loop_idx_q;
    any_idx_d  = any_idx_q;
    coll_d     = coll_q;
    busy_d     = busy_q;
    hcnt_d     = hcnt_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    pick       = '0;
    reason     = REASON_FREE;
    upd        = fent_q;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d      = cmd_e'(s_axis_tuser);
          snd_d      = s_axis_tdata[7:0];
          loop_d     = s_axis_tdata[8];
          hdl_d      = s_axis_tdata[40:9];
          end_d      = s_axis_tdata[46:41];
          // Next handle skips zero when the counter wraps.
          nh_d       = (cnt_inc == 32'd0) ? 32'd1 : cnt_inc;
          cnt_d      = '0;
          find_vld_d = 1'b0;
          best_d     = '0;
          coll_d     = '0;
        end
      end

      ST_SCAN: begin
        if (issuing) begin
          cnt_d  = cnt_q + 1'b1;
          pend_d = 1'b1;
          pidx_d = cnt_q[CW-1:0];
        end
        if (pend_q) begin
          if (cmp_res.key_hit) begin
            coll_d[pidx_q] = 1'b1;
            if (!find_vld_q) begin
              find_vld_d = 1'b1;
              fidx_d     = pidx_q;
              fent_d     = ram_rdata;
            end
          end
          if (cmp_res.same_better) begin
            best_d.same_vld = 1'b1;
            best_d.same_h   = ram_rdata.handle;
            same_idx_d      = pidx_q;
          end
          if (cmp_res.loop_better) begin
            best_d.loop_vld = 1'b1;
            best_d.loop_h   = ram_rdata.handle;
            loop_idx_d      = pidx_q;
          end
          if (cmp_res.any_better) begin
            best_d.any_vld = 1'b1;
            best_d.any_h   = ram_rdata.handle;
            any_idx_d      = pidx_q;
          end
        end
      end

      ST_WRITE: begin
        res_d        = '0;
        res_d.action = ACT_NONE;
        unique case (cmd_q)
          CMD_PLAY: begin
            priority if (free_vld) begin
              pick   = free_idx;
              reason = REASON_FREE;
            end else if (best_q.same_vld) begin
              pick   = same_idx_q;
              reason = REASON_SAME;
            end else if (best_q.loop_vld) begin
              pick   = loop_idx_q;
              reason = REASON_LOOPING;
            end else begin
              pick   = any_idx_q;
              reason = REASON_OLDEST;
            end
            // Channels still holding the new handle are dropped silently.
            busy_d       = busy_q & ~coll_q;
            busy_d[pick] = 1'b1;
            hcnt_d       = nh_q;
            ram_we       = 1'b1;
            ram_waddr    = pick;
            ram_wdata.handle  = nh_q;
            ram_wdata.sound   = snd_q;
            ram_wdata.looping = loop_q;
            ram_wdata.paused  = 1'b0;
            res_d.action        = ACT_START;
            res_d.channel       = 6'(pick);
            res_d.new_handle    = nh_q;
            res_d.start_looping = loop_q;
            res_d.start_sound   = snd_q;
            res_d.steal_reason  = reason;
          end
          CMD_STOP: begin
            if (find_vld_q) begin
              busy_d[fidx_q] = 1'b0;
              res_d.action   = ACT_HALT;
              res_d.channel  = 6'(fidx_q);
            end else begin
              res_d.status = STATUS_UNKNOWN;
            end
          end
          CMD_PAUSE, CMD_RESUME: begin
            if (!find_vld_q) begin
              res_d.status = STATUS_UNKNOWN;
            end else if (fent_q.paused == (cmd_q == CMD_RESUME)) begin
              upd.paused    = (cmd_q == CMD_PAUSE);
              ram_we        = 1'b1;
              ram_waddr     = fidx_q;
              ram_wdata     = upd;
              res_d.action  = (cmd_q == CMD_PAUSE) ? ACT_PAUSE : ACT_RESUME;
              res_d.channel = 6'(fidx_q);
            end
          end
          CMD_QUERY: begin
            if (find_vld_q) begin
              res_d.sound_state = fent_q.paused ? SSTATE_PAUSED : SSTATE_PLAYING;
            end else begin
              res_d.sound_state = SSTATE_STOPPED;
            end
          end
          CMD_STOPALL: begin
            busy_d       = '0;
            res_d.action = ACT_HALTALL;
          end
          CMD_ENDED: begin
            if ({1'b0, end_q} < NUM_CH7) begin
              busy_d[end_q[CW-1:0]] = 1'b0;
            end
          end
          default: begin
            res_d.status = STATUS_OK;
          end
        endcase
      end

      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
        end
      end

      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      busy_q    <= '0;
      hcnt_q    <= '0;
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      busy_q    <= busy_d;
      hcnt_q    <= hcnt_d;
      out_vld_q <= out_vld_d;
      pend_q    <= pend_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    snd_q      <= snd_d;
    loop_q     <= loop_d;
    hdl_q      <= hdl_d;
    end_q      <= end_d;
    nh_q       <= nh_d;
    pidx_q     <= pidx_d;
    find_vld_q <= find_vld_d;
    fidx_q     <= fidx_d;
    fent_q     <= fent_d;
    best_q     <= best_d;
    same_idx_q <= same_idx_d;
    loop_idx_q <= loop_idx_d;
    any_idx_q  <= any_idx_d;
    coll_q     <= coll_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.action;
  assign m_axis_tdata  = {3'b000, out_q.sound_state, out_q.steal_reason, out_q.start_sound,
                          out_q.start_looping, out_q.new_handle, out_q.channel,
                          out_q.status};

endmodule

`default_nettype wire
